>>> rtl/igl_pkg.sv
// shared types and constants for the integer gcd / lcm unit
// holds field widths, request codes, controller states and the command/status structs
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package igl_pkg;

    localparam int MAG_BITS_DEF = 53;
    localparam int OPND_W       = 55;
    localparam int RES_W        = 63;
    localparam int S_TDATA_W    = 112;
    localparam int M_TDATA_W    = 64;

    localparam logic REQ_GCD = 1'b0;
    localparam logic REQ_LCM = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_GCD,
        ST_DIV,
        ST_MUL,
        ST_FIN
    } igl_state_t;

    typedef struct packed {
        logic load;
        logic gcd_step;
        logic gcd_fin;
        logic div_step;
        logic mul_step;
        logic out_load;
    } igl_cmd_t;

    typedef struct packed {
        logic gcd_done;
        logic lcm_path;
    } igl_sts_t;

endpackage

`default_nettype wire

>>> rtl/igl_dp.sv
// datapath of the gcd / lcm unit: operand magnitudes, binary gcd, restoring divider,
// serial shift-add multiplier with saturation, and the output register
// depends on igl_pkg
`timescale 1ns / 1ps
`default_nettype none

module igl_dp #(
    parameter int MAG_BITS = igl_pkg::MAG_BITS_DEF
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire igl_pkg::igl_cmd_t              cmd,
    output igl_pkg::igl_sts_t                   sts,
    input  wire logic [igl_pkg::S_TDATA_W-1:0]  s_tdata,
    input  wire logic                           s_tuser,
    output logic      [igl_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic                                m_tuser
);

    localparam int MW    = MAG_BITS + 1;
    localparam int KW    = $clog2(MW);
    localparam int OW    = igl_pkg::OPND_W;
    localparam int RW    = igl_pkg::RES_W;
    localparam int CMPW  = (MW > OW) ? MW : OW;
    localparam logic [CMPW-1:0] MAG_LIMIT = CMPW'(1) << MAG_BITS;

    logic [OW-1:0]   raw_a;
    logic [OW-1:0]   raw_b;
    logic [OW-1:0]   abs_a;
    logic [OW-1:0]   abs_b;
    logic [CMPW-1:0] ext_a;
    logic [CMPW-1:0] ext_b;
    logic [CMPW-1:0] sat_a;
    logic [CMPW-1:0] sat_b;

    logic          lcm_reg,  lcm_next;
    logic [MW-1:0] ma_reg,   ma_next;
    logic [MW-1:0] mb_reg,   mb_next;
    logic [MW-1:0] x_reg,    x_next;
    logic [MW-1:0] y_reg,    y_next;
    logic [KW-1:0] k_reg,    k_next;
    logic [MW-1:0] g_reg,    g_next;
    logic [MW-1:0] rem_reg,  rem_next;
    logic [MW-1:0] quo_reg,  quo_next;
    logic [RW-1:0] acc_reg,  acc_next;
    logic          ovf_reg,  ovf_next;
    logic [RW-1:0] res_reg,  res_next;
    logic          rovf_reg, rovf_next;

    logic [MW:0]   xy_diff;
    logic [MW:0]   yx_diff;
    logic [MW-1:0] gcd_val;
    logic [MW:0]   div_shift;
    logic [MW:0]   div_trial;
    logic [RW+1:0] mul_sum;
    logic [RW+1:0] mul_addend;

    // operand magnitudes, most negative input included, clamped to 2^MAG_BITS
    assign raw_a = s_tdata[OW-1:0];
    assign raw_b = s_tdata[2*OW-1:OW];
    assign abs_a = raw_a[OW-1] ? (~raw_a + OW'(1)) : raw_a;
    assign abs_b = raw_b[OW-1] ? (~raw_b + OW'(1)) : raw_b;
    assign ext_a = CMPW'(abs_a);
    assign ext_b = CMPW'(abs_b);
    assign sat_a = (ext_a > MAG_LIMIT) ? MAG_LIMIT : ext_a;
    assign sat_b = (ext_b > MAG_LIMIT) ? MAG_LIMIT : ext_b;

    assign xy_diff    = {1'b0, x_reg} - {1'b0, y_reg};
    assign yx_diff    = {1'b0, y_reg} - {1'b0, x_reg};
    assign gcd_val    = (x_reg | y_reg) << k_reg;
    assign div_shift  = {rem_reg, quo_reg[MW-1]};
    assign div_trial  = div_shift - {1'b0, g_reg};
    assign mul_addend = quo_reg[MW-1] ? (RW+2)'(mb_reg) : '0;
    assign mul_sum    = {1'b0, acc_reg, 1'b0} + mul_addend;

    assign sts.gcd_done = (x_reg == '0) || (y_reg == '0);
    assign sts.lcm_path = (lcm_reg == igl_pkg::REQ_LCM) && (ma_reg != '0) && (mb_reg != '0);

    always_comb begin
        lcm_next  = lcm_reg;
        ma_next   = ma_reg;
        mb_next   = mb_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        k_next    = k_reg;
        g_next    = g_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        acc_next  = acc_reg;
        ovf_next  = ovf_reg;
        res_next  = res_reg;
        rovf_next = rovf_reg;

        if (cmd.load) begin
            lcm_next = s_tuser;
            ma_next  = sat_a[MW-1:0];
            mb_next  = sat_b[MW-1:0];
            x_next   = sat_a[MW-1:0];
            y_next   = sat_b[MW-1:0];
            k_next   = '0;
        end

        // binary gcd: one shift or one subtract-and-shift per step
        if (cmd.gcd_step) begin
            if (!x_reg[0] && !y_reg[0]) begin
                x_next = x_reg >> 1;
                y_next = y_reg >> 1;
                k_next = k_reg + KW'(1);
            end else if (!x_reg[0]) begin
                x_next = x_reg >> 1;
            end else if (!y_reg[0]) begin
                y_next = y_reg >> 1;
            end else if (!xy_diff[MW]) begin
                x_next = xy_diff[MW-1:0] >> 1;
            end else begin
                y_next = yx_diff[MW-1:0] >> 1;
            end
        end

        if (cmd.gcd_fin) begin
            g_next   = gcd_val;
            quo_next = ma_reg;
            rem_next = '0;
            acc_next = '0;
            ovf_next = 1'b0;
        end

        // restoring division of |a| by the gcd, one quotient bit per step
        if (cmd.div_step) begin
            if (!div_trial[MW]) begin
                rem_next = div_trial[MW-1:0];
                quo_next = {quo_reg[MW-2:0], 1'b1};
            end else begin
                rem_next = div_shift[MW-1:0];
                quo_next = {quo_reg[MW-2:0], 1'b0};
            end
        end

        // msb-first shift-add; partial products only grow, so overflow is sticky
        if (cmd.mul_step) begin
            quo_next = {quo_reg[MW-2:0], 1'b0};
            acc_next = mul_sum[RW-1:0];
            ovf_next = ovf_reg | (mul_sum[RW+1:RW] != 2'b00);
        end

        if (cmd.out_load) begin
            if (lcm_reg == igl_pkg::REQ_GCD) begin
                res_next  = RW'(g_reg);
                rovf_next = 1'b0;
            end else if (sts.lcm_path) begin
                res_next  = ovf_reg ? '1 : acc_reg;
                rovf_next = ovf_reg;
            end else begin
                res_next  = '0;
                rovf_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        lcm_reg  <= lcm_next;
        ma_reg   <= ma_next;
        mb_reg   <= mb_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        k_reg    <= k_next;
        g_reg    <= g_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        acc_reg  <= acc_next;
        ovf_reg  <= ovf_next;
        res_reg  <= res_next;
        rovf_reg <= rovf_next;
    end

    assign m_tdata = {{(igl_pkg::M_TDATA_W - RW){1'b0}}, res_reg};
    assign m_tuser = rovf_reg;

    // gcd steps never grow either operand
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.gcd_step |=> (x_reg <= $past(x_reg)) && (y_reg <= $past(y_reg)))
        else $error("gcd step increased an operand");

    // the divider only runs on a nonzero gcd
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_step |-> (g_reg != '0))
        else $error("division by zero gcd");

endmodule

`default_nettype wire

>>> rtl/igl_ctrl.sv
// controller of the gcd / lcm unit: sequences load, gcd, divide, multiply and output
// owns the input ready, the output valid and the step counter
// depends on igl_pkg
`timescale 1ns / 1ps
`default_nettype none

module igl_ctrl #(
    parameter int MAG_BITS = igl_pkg::MAG_BITS_DEF
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    input  wire igl_pkg::igl_sts_t  sts,
    output igl_pkg::igl_cmd_t       cmd
);

    localparam int MW    = MAG_BITS + 1;
    localparam int CNT_W = $clog2(MW);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MW - 1);

    igl_pkg::igl_state_t state_reg, state_next;
    logic [CNT_W-1:0]    cnt_reg,   cnt_next;
    logic                m_valid_reg, m_valid_next;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            igl_pkg::ST_IDLE: begin
                if (s_tvalid) state_next = igl_pkg::ST_GCD;
            end
            igl_pkg::ST_GCD: begin
                if (sts.gcd_done) state_next = sts.lcm_path ? igl_pkg::ST_DIV : igl_pkg::ST_FIN;
            end
            igl_pkg::ST_DIV: begin
                if (cnt_reg == CNT_LAST) state_next = igl_pkg::ST_MUL;
            end
            igl_pkg::ST_MUL: begin
                if (cnt_reg == CNT_LAST) state_next = igl_pkg::ST_FIN;
            end
            igl_pkg::ST_FIN: begin
                if (!m_valid_reg || m_tready) state_next = igl_pkg::ST_IDLE;
            end
            default: begin
                state_next = igl_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        cnt_next = cnt_reg;
        case (state_reg)
            igl_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            igl_pkg::ST_GCD: begin
                if (sts.gcd_done) begin
                    cmd.gcd_fin = 1'b1;
                    cnt_next    = '0;
                end else begin
                    cmd.gcd_step = 1'b1;
                end
            end
            igl_pkg::ST_DIV: begin
                cmd.div_step = 1'b1;
                cnt_next     = (cnt_reg == CNT_LAST) ? '0 : cnt_reg + CNT_W'(1);
            end
            igl_pkg::ST_MUL: begin
                cmd.mul_step = 1'b1;
                cnt_next     = cnt_reg + CNT_W'(1);
            end
            igl_pkg::ST_FIN: begin
                // result moves into the output register once it is free
                cmd.out_load = !m_valid_reg || m_tready;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

    assign m_valid_next = cmd.out_load | (m_valid_reg & ~m_tready);
    assign m_tvalid     = m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= igl_pkg::ST_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg == igl_pkg::ST_GCD))
        else $error("accepted item did not start the gcd");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == igl_pkg::ST_DIV && cnt_reg == CNT_LAST) |=>
        (state_reg == igl_pkg::ST_MUL && cnt_reg == '0))
        else $error("divide did not hand over to multiply");

    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> ($past(state_reg) == igl_pkg::ST_FIN))
        else $error("result shown without finishing an item");

endmodule

`default_nettype wire

>>> rtl/integer_gcd_lcm_unit.sv
// usage:
//   input item: s_tdata = operand_a [54:0], operand_b [109:55], zero pad [111:110];
//   s_tuser = req_type (0 gcd, 1 lcm). taken when s_tvalid and s_tready are high.
//   result item: m_tdata = result_value [62:0], zero pad [63]; m_tuser = overflow.
//   one result per item, in order.
// sequencing:
//   one item at a time; s_tready is high only while the unit is idle.
//   the binary gcd runs one shift or subtract per cycle, none when an operand is zero.
//   lcm then adds a restoring divide and a shift-add multiply.
// stall: the result sits in an output register, so the next item is taken while it
//   waits; the unit holds at the end of that next item until the register frees.
// reset: aresetn synchronous, active low; clears control state, no item in flight.
// lcm above 2^63-1 gives 2^63-1 with overflow set.
// depends on igl_pkg, igl_ctrl, igl_dp
`timescale 1ns / 1ps
`default_nettype none

module integer_gcd_lcm_unit #(
    parameter int MAG_BITS = igl_pkg::MAG_BITS_DEF
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [igl_pkg::S_TDATA_W-1:0]  s_tdata,   // operand_a, operand_b
    input  wire logic                           s_tuser,   // req_type
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic      [igl_pkg::M_TDATA_W-1:0]  m_tdata,   // result_value
    output logic                                m_tuser    // overflow
);

    igl_pkg::igl_cmd_t cmd;
    igl_pkg::igl_sts_t sts;

    igl_ctrl #(
        .MAG_BITS (MAG_BITS)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    igl_dp #(
        .MAG_BITS (MAG_BITS)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .sts      (sts),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

`default_nettype wire
